[rtl/fpa_pkg.sv]
// Shared types, opcode and status codes and saturation helpers for the
// fixed-point ALU. No dependencies.
package fpa_pkg;

  // Opcodes
  localparam logic [3:0] CMD_ADD  = 4'd0;
  localparam logic [3:0] CMD_SUB  = 4'd1;
  localparam logic [3:0] CMD_MUL  = 4'd2;
  localparam logic [3:0] CMD_DIV  = 4'd3;
  localparam logic [3:0] CMD_GT   = 4'd4;
  localparam logic [3:0] CMD_LT   = 4'd5;
  localparam logic [3:0] CMD_GE   = 4'd6;
  localparam logic [3:0] CMD_LE   = 4'd7;
  localparam logic [3:0] CMD_EQ   = 4'd8;
  localparam logic [3:0] CMD_NE   = 4'd9;
  localparam logic [3:0] CMD_MAX  = 4'd10;
  localparam logic [3:0] CMD_MIN  = 4'd11;
  localparam logic [3:0] CMD_INC  = 4'd12;
  localparam logic [3:0] CMD_DEC  = 4'd13;
  localparam logic [3:0] CMD_FINT = 4'd14;
  localparam logic [3:0] CMD_TINT = 4'd15;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  // Result carried alongside the divider chain
  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
    logic        is_div;
    logic        neg;
    logic        b_zero;
  } side_t;

  typedef struct packed {
    logic [31:0] value;
    logic        ovf;
  } sat_t;

  // Apply sign to a magnitude and saturate to a w-bit signed range
  function automatic sat_t sat_mag(logic [63:0] m, logic neg, int unsigned w);
    logic [63:0] lim;
    logic [63:0] tmp;
    sat_t        r;
    lim   = 64'd1 << (w - 1);
    r.ovf = 1'b0;
    if (neg) begin
      if (m > lim) begin
        r.ovf = 1'b1;
        tmp   = ~lim + 64'd1;
      end else begin
        tmp = ~m + 64'd1;
      end
    end else begin
      if (m > lim - 64'd1) begin
        r.ovf = 1'b1;
        tmp   = lim - 64'd1;
      end else begin
        tmp = m;
      end
    end
    r.value = tmp[31:0];
    return r;
  endfunction

  // Saturate a signed 64-bit value to w bits
  function automatic sat_t clamp(logic [63:0] x, int unsigned w);
    sat_t r;
    if (x[63]) begin
      r = sat_mag(~x + 64'd1, 1'b1, w);
    end else begin
      r = sat_mag(x, 1'b0, w);
    end
    return r;
  endfunction

endpackage

[rtl/fpa_div_cell.sv]
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
// Depends on fpa_pkg.
module fpa_div_cell #(
  parameter int N = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  fpa_pkg::side_t  side_i,
  input  logic [31:0]     rem_i,
  input  logic [N-1:0]    dividend_i,
  input  logic [N-1:0]    quot_i,
  input  logic [31:0]     divisor_i,
  output logic            valid_o,
  output fpa_pkg::side_t  side_o,
  output logic [31:0]     rem_o,
  output logic [N-1:0]    dividend_o,
  output logic [N-1:0]    quot_o,
  output logic [31:0]     divisor_o
);
  import fpa_pkg::*;

  logic [32:0] sh;
  logic [32:0] diff;
  logic        ge;
  logic [31:0] rem_d;

  // Shift in next dividend bit, trial subtract
  assign sh    = {rem_i, dividend_i[N-1]};
  assign ge    = sh >= {1'b0, divisor_i};
  assign diff  = sh - {1'b0, divisor_i};
  assign rem_d = ge ? diff[31:0] : sh[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o     <= side_i;
    rem_o      <= rem_d;
    dividend_o <= {dividend_i[N-2:0], 1'b0};
    quot_o     <= {quot_i[N-2:0], ge};
    divisor_o  <= divisor_i;
  end

endmodule

[rtl/fixed_point_alu.sv]
// Top level of the signed fixed-point ALU: operand stage, divider cell
// chain and result stage. Depends on fpa_pkg and fpa_div_cell.
//
// Usage:
//   Command channel: start_i with command_i, operand_a_i, operand_b_i. A
//   transfer happens at every rising edge with start_i high and busy_o low;
//   busy_o is never raised, so one command may be issued every cycle.
//   Result channel: done_o strobes for one cycle with result_value_o,
//   compare_flag_o and status_o. The receiver cannot stall the block.
//   Every opcode takes the same path from a command's transfer to its
//   done_o strobe, so results leave in issue order. Throughput: one
//   command per cycle.
//   The path runs through one operand stage (multiplier), a chain of
//   32 + FRAC_BITS divider cells, one quotient bit per cell, and one
//   result stage (rounding and saturation).
//   Reset clears all valid flags; commands in flight are dropped.
module fixed_point_alu #(
  parameter int FRAC_BITS  = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  command_i,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic        compare_flag_o,
  output logic [1:0]  status_o
);
  import fpa_pkg::*;

  localparam int W   = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int N   = 32 + FRAC_BITS;
  localparam int LAT = N + 2;

  logic        [W-1:0] aw, bw;
  logic signed [63:0]  a64, b64;
  logic        [63:0]  ma, mb;
  logic                accept;
  side_t               side_d;
  sat_t                s_tmp;
  logic        [63:0]  vmax64, vmin64;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Sign extend operands from W bits
  assign aw  = operand_a_i[W-1:0];
  assign bw  = operand_b_i[W-1:0];
  assign a64 = 64'(signed'(aw));
  assign b64 = 64'(signed'(bw));
  assign ma  = a64[63] ? (~a64 + 64'd1) : a64;
  assign mb  = b64[63] ? (~b64 + 64'd1) : b64;

  assign vmax64 = (64'd1 << (W - 1)) - 64'd1;
  assign vmin64 = ~vmax64;

  // Combinational operations and side information
  always_comb begin
    side_d        = '0;
    s_tmp         = '0;
    side_d.is_div = (command_i == CMD_DIV);
    side_d.neg    = a64[63] ^ b64[63];
    side_d.b_zero = (b64 == 64'sd0);
    unique case (command_i)
      CMD_ADD: s_tmp = clamp(a64 + b64, W);
      CMD_SUB: s_tmp = clamp(a64 - b64, W);
      CMD_MUL: s_tmp = '0;
      CMD_DIV: begin
        s_tmp.value = a64[63] ? vmin64[31:0] : vmax64[31:0];
      end
      CMD_GT:  side_d.flag = a64 > b64;
      CMD_LT:  side_d.flag = a64 < b64;
      CMD_GE:  side_d.flag = a64 >= b64;
      CMD_LE:  side_d.flag = a64 <= b64;
      CMD_EQ:  side_d.flag = a64 == b64;
      CMD_NE:  side_d.flag = a64 != b64;
      CMD_MAX: s_tmp.value = (a64 >= b64) ? a64[31:0] : b64[31:0];
      CMD_MIN: s_tmp.value = (a64 <= b64) ? a64[31:0] : b64[31:0];
      CMD_INC: s_tmp = clamp(a64 + 64'sd1, W);
      CMD_DEC: s_tmp = clamp(a64 - 64'sd1, W);
      CMD_FINT: s_tmp = sat_mag(ma << FRAC_BITS, a64[63], W);
      CMD_TINT: begin
        s_tmp.value = 32'(a64 >>> FRAC_BITS);
      end
      default: s_tmp = '0;
    endcase
    side_d.value = s_tmp.value;
    if (command_i == CMD_DIV && side_d.b_zero) begin
      side_d.status = ST_DIV0;
    end else if (s_tmp.ovf) begin
      side_d.status = ST_OVF;
    end else begin
      side_d.status = ST_OK;
    end
  end

  // Operand stage: multiplier and divider seeds
  logic          s1_v_q;
  side_t         s1_side_q;
  logic          s1_mul_q;
  logic [63:0]   s1_prod_q;
  logic [N-1:0]  s1_dvd_q;
  logic [31:0]   s1_dvs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_side_q <= side_d;
    s1_mul_q  <= (command_i == CMD_MUL);
    s1_prod_q <= 64'(ma[31:0]) * 64'(mb[31:0]);
    s1_dvd_q  <= N'(ma[31:0]) << FRAC_BITS;
    s1_dvs_q  <= mb[31:0];
  end

  // Multiply rounding and saturation before the chain
  side_t       c0_side;
  sat_t        mul_sat;
  logic [63:0] mul_q;

  assign mul_q   = (s1_prod_q >> FRAC_BITS) + 64'(s1_prod_q[FRAC_BITS-1]);
  assign mul_sat = sat_mag(mul_q, s1_side_q.neg, W);

  always_comb begin
    c0_side = s1_side_q;
    if (s1_mul_q) begin
      c0_side.value  = mul_sat.value;
      c0_side.status = mul_sat.ovf ? ST_OVF : ST_OK;
    end
  end

  // Divider cell chain
  logic          cv   [0:N];
  side_t         cside[0:N];
  logic [31:0]   crem [0:N];
  logic [N-1:0]  cdvd [0:N];
  logic [N-1:0]  cquo [0:N];
  logic [31:0]   cdvs [0:N];

  assign cv[0]    = s1_v_q;
  assign cside[0] = c0_side;
  assign crem[0]  = '0;
  assign cdvd[0]  = s1_dvd_q;
  assign cquo[0]  = '0;
  assign cdvs[0]  = s1_dvs_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_div_cell #(.N(N)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .valid_i    (cv[i]),
      .side_i     (cside[i]),
      .rem_i      (crem[i]),
      .dividend_i (cdvd[i]),
      .quot_i     (cquo[i]),
      .divisor_i  (cdvs[i]),
      .valid_o    (cv[i+1]),
      .side_o     (cside[i+1]),
      .rem_o      (crem[i+1]),
      .dividend_o (cdvd[i+1]),
      .quot_o     (cquo[i+1]),
      .divisor_o  (cdvs[i+1])
    );
  end

  // Divide rounding, saturation and output select
  side_t       fin;
  logic        div_rnd;
  sat_t        div_sat;
  logic        done_q;
  logic [31:0] res_q;
  logic        flag_q;
  logic [1:0]  st_q;

  assign fin     = cside[N];
  assign div_rnd = {crem[N], 1'b0} >= {1'b0, cdvs[N]};
  assign div_sat = sat_mag(64'(cquo[N]) + 64'(div_rnd), fin.neg, W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cv[N];
    end
  end

  always_ff @(posedge clk_i) begin
    flag_q <= fin.flag;
    if (fin.is_div && !fin.b_zero) begin
      res_q <= div_sat.value;
      st_q  <= div_sat.ovf ? ST_OVF : ST_OK;
    end else begin
      res_q <= fin.value;
      st_q  <= fin.status;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign compare_flag_o = flag_q;
  assign status_o       = st_q;

  // Checks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT done_o) else $error("result strobe missing");
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_OK || status_o == ST_OVF || status_o == ST_DIV0))
    else $error("bad status code");
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && compare_flag_o |-> result_value_o == 32'd0 && status_o == ST_OK)
    else $error("comparison result not clean");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cv[N] |=> !done_o) else $error("unexpected result strobe");

endmodule

[test/tb_fixed_point_alu.sv]
// Testbench for the signed fixed-point ALU (Q24.8, 32-bit raw values).
// Drives commands through start_i/busy_o, predicts each result in the bench
// and checks done_o transfers in order. Depends on fpa_pkg and the ALU RTL.
`timescale 1ns / 100ps

module tb_fixed_point_alu;
  import fpa_pkg::*;

  localparam int FRAC = 8;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LATENCY = 34 + FRAC;

  typedef struct packed {
    logic [31:0] value;
    logic        flag;
    logic [1:0]  status;
  } alu_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [3:0]  command_i = '0;
  logic [31:0] operand_a_i = '0;
  logic [31:0] operand_b_i = '0;
  logic        busy_o, done_o, compare_flag_o;
  logic [31:0] result_value_o;
  logic [1:0]  status_o;

  alu_res_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  bit calm = 1'b0;

  fixed_point_alu #(.FRAC_BITS(FRAC), .DATA_WIDTH(32)) dut (.*);

  // Clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Saturate a signed value to the 32-bit range
  function automatic longint sat32(longint x, ref logic [1:0] st);
    if (x > VMAX) begin st = ST_OVF; return VMAX; end
    if (x < VMIN) begin st = ST_OVF; return VMIN; end
    return x;
  endfunction

  // Expected ALU result for one command
  function automatic alu_res_t alu_predict(logic [3:0] cmd, logic [31:0] ra, logic [31:0] rb);
    longint a, b, r, ma, mb, q, rem;
    logic [63:0] m;
    logic [1:0] st;
    logic flag;
    alu_res_t res;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = 0; st = ST_OK; flag = 1'b0;
    case (cmd)
      CMD_ADD: r = sat32(a + b, st);
      CMD_SUB: r = sat32(a - b, st);
      CMD_MUL: begin
        m = 64'(ma) * 64'(mb);
        q = longint'(m >> FRAC);
        if (m[FRAC-1]) q++;
        r = sat32(((a < 0) != (b < 0)) ? -q : q, st);
      end
      CMD_DIV: begin
        if (b == 0) begin
          st = ST_DIV0;
          r = a < 0 ? VMIN : VMAX;
        end else begin
          q = (ma <<< FRAC) / mb;
          rem = (ma <<< FRAC) % mb;
          if (rem >= mb - rem) q++;
          r = sat32(((a < 0) != (b < 0)) ? -q : q, st);
        end
      end
      CMD_GT: flag = a > b;
      CMD_LT: flag = a < b;
      CMD_GE: flag = a >= b;
      CMD_LE: flag = a <= b;
      CMD_EQ: flag = a == b;
      CMD_NE: flag = a != b;
      CMD_MAX: r = a >= b ? a : b;
      CMD_MIN: r = a <= b ? a : b;
      CMD_INC: r = sat32(a + 1, st);
      CMD_DEC: r = sat32(a - 1, st);
      CMD_FINT: r = sat32(a <<< FRAC, st);
      default: r = a >>> FRAC;
    endcase
    res.value = r[31:0];
    res.flag = flag;
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR @%0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  // Issue one command; start_i stays high when the next one follows at once
  task automatic issue_cmd(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    int gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(alu_predict(cmd, a, b));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    start_i <= 1'b0;
  endtask

  // Check every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", result_value_o, 32'h0);
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (result_value_o !== want.value)
          report_mismatch("result_value", result_value_o, want.value);
        if (compare_flag_o !== want.flag)
          report_mismatch("compare_flag", 32'(compare_flag_o), 32'(want.flag));
        if (status_o !== want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  // Directed extremes, every opcode and the special cases
  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7fffffff; mn = 32'h80000000;
    for (int c = 0; c < 16; c++) issue_cmd(4'(c), 32'h00000180, 32'hffffff00);
    issue_cmd(CMD_ADD, mx, 32'd1);
    issue_cmd(CMD_SUB, mn, 32'd1);
    issue_cmd(CMD_MUL, mn, mn);
    issue_cmd(CMD_MUL, 32'd1, 32'h80);            // tie rounds away from zero
    issue_cmd(CMD_MUL, 32'hffffffff, 32'h80);
    issue_cmd(CMD_DIV, 32'd5, 32'd0);             // divide by zero, positive
    issue_cmd(CMD_DIV, mn, 32'd0);                // divide by zero, negative
    issue_cmd(CMD_DIV, mn, 32'hffffffff);
    issue_cmd(CMD_INC, mx, mn);
    issue_cmd(CMD_DEC, mn, mx);
    issue_cmd(CMD_FINT, mn, 32'd0);
    issue_cmd(CMD_TINT, 32'hffffffff, mx);
  endtask

  // Random commands, with idle bursts from the sender unless calm is set
  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      issue_cmd(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  // Hold off until the pipeline has drained, then send 100 random commands
  task automatic test_drain_pause();
    go_idle();
    while (expected_q.size() != 0) @(negedge clk_i);
    test_random(100);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(800);
    test_drain_pause();
    calm = 1'b1;
    test_random(850);
    go_idle();
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    $display("Sent %0d commands over all 16 opcodes, checked %0d results,", n_sent, n_checked);
    $display("with operand extremes, overflow, rounding ties and divide by zero.");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TIMEOUT");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
